>>> hdl/rhht_pkg.sv
// rhht_pkg: shared types, constants and codes of the robin hood hash table
// no dependencies
package rhht_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int KEY_BITS_DEF  = 64;
  localparam int HASH_BITS_DEF = 32;

  localparam logic [15:0] MAX_PROBE_RST  = 16'd10;
  localparam logic [10:0] LOAD_LIMIT_RST = 11'd921;

  localparam logic [0:0] REG_MAX_PROBE  = 1'b0;
  localparam logic [0:0] REG_LOAD_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UPDATE = 2'd1,
    OP_GET    = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_REMOVED   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;   // write empty slot at clear address
    logic load;       // latch request
    logic rd;         // restart walk from home slot for placement
    logic srch_step;  // advance search walk
    logic place_wr;   // write placement step
    logic upd_wr;     // overwrite value at walk index
    logic rm_clear;   // clear gap slot
    logic shift_wr;   // move next slot into gap
    logic gap_clr;    // empty the last gap of the shift
    logic finish;     // produce result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic slot_valid;
    logic slot_match;
    logic stop_early;   // dist > slot probe
    logic swap;         // carried probe > slot probe
    logic full;
    logic shift_stop;   // next slot empty or at home
    logic walk_end;     // walk ran full capacity
    logic is_mut;       // insert or update
    logic is_upd;
    logic is_get;
  } dp_sts_t;

endpackage

>>> hdl/rhht_datapath.sv
// rhht_datapath: slot memory, request registers, walk index, counters
// depends on rhht_pkg
module rhht_datapath #(
  parameter int CAPACITY  = rhht_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = rhht_pkg::KEY_BITS_DEF,
  parameter int HASH_BITS = rhht_pkg::HASH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rhht_pkg::dp_cmd_t   cmd,
  output rhht_pkg::dp_sts_t   sts,
  input  logic [1:0]          in_operation,
  input  logic [31:0]         in_hash,
  input  logic [63:0]         in_key,
  input  logic [63:0]         in_value,
  input  logic [3:0]          in_value_bytes,
  input  logic [15:0]         max_probe,
  input  logic [10:0]         load_limit,
  input  rhht_pkg::status_t   res_status,
  output logic                out_valid,
  output logic [2:0]          out_status,
  output logic [63:0]         out_read_value,
  output logic [3:0]          out_read_bytes,
  output logic [10:0]         out_probe_count,
  output logic                out_over_probe,
  output logic [10:0]         out_entry_total
);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = AW + 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  key;
    logic [HASH_BITS-1:0] hash;
    logic [63:0]          value;
    logic [3:0]           bytes;
    logic [PW-1:0]        probe;
  } slot_t;

  slot_t mem [CAPACITY];
  slot_t rd_r;
  slot_t car_r, car_nxt;
  logic [AW-1:0] idx_r, idx_nxt, clr_r;
  logic          clr_done_r;
  logic [PW-1:0] dist_r, dist_nxt, walk_r, walk_nxt;
  logic [1:0]    op_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [10:0]   probes_r, probes_nxt;
  logic          over_r, over_nxt;
  logic [63:0]   vmask;
  logic [3:0]    nb;
  logic [CW:0]   limit;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data, moved;

  assign nb = (in_value_bytes > 4'd8) ? 4'd8 : in_value_bytes;
  assign vmask = (nb == 4'd0) ? 64'd0 : (~64'd0 >> (7'd64 - {nb, 3'b000}));
  assign limit = (32'(load_limit) < CAPACITY) ? (CW+1)'(load_limit)
                                              : (CW+1)'(CAPACITY);

  always_comb begin
    moved = rd_r;
    moved.probe = rd_r.probe - PW'(1);
    wr_en = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_r;
    if (cmd.clr_step) begin
      wr_en = 1'b1;
      wr_addr = clr_r;
      wr_data = '0;
    end else if (cmd.place_wr && (!rd_r.valid || car_r.probe > rd_r.probe)) begin
      wr_en = 1'b1;
      wr_data = car_r;
    end else if (cmd.upd_wr) begin
      wr_en = 1'b1;
      wr_data.value = car_r.value;
      wr_data.bytes = car_r.bytes;
    end else if (cmd.rm_clear) begin
      wr_en = 1'b1;
      wr_data = '0;
    end else if (cmd.shift_wr) begin
      wr_en = 1'b1;
      wr_addr = idx_r - AW'(1);
      wr_data = moved;
    end else if (cmd.gap_clr) begin
      wr_en = 1'b1;
      wr_addr = idx_r - AW'(1);
      wr_data = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[idx_nxt];
  end

  always_comb begin
    idx_nxt = idx_r;
    dist_nxt = dist_r;
    walk_nxt = walk_r;
    car_nxt = car_r;
    probes_nxt = probes_r;
    over_nxt = over_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      idx_nxt = in_hash[AW-1:0];
      dist_nxt = '0;
      walk_nxt = '0;
      car_nxt.valid = 1'b1;
      car_nxt.key = in_key[KEY_BITS-1:0];
      car_nxt.hash = in_hash[HASH_BITS-1:0];
      car_nxt.value = in_value & vmask;
      car_nxt.bytes = nb;
      car_nxt.probe = '0;
      // home slot counts as the first probe
      probes_nxt = 11'd1;
      over_nxt = 1'b0;
    end
    if (cmd.srch_step) begin
      probes_nxt = probes_r + 11'd1;
      idx_nxt = idx_r + AW'(1);
      dist_nxt = dist_r + PW'(1);
      walk_nxt = walk_r + PW'(1);
    end
    if (cmd.place_wr) begin
      probes_nxt = probes_r + 11'd1;
      walk_nxt = walk_r + PW'(1);
      if (!rd_r.valid) begin
        cnt_nxt = cnt_r + CW'(1);
      end else begin
        if (car_r.probe > rd_r.probe) car_nxt = rd_r;
        car_nxt.probe = ((car_r.probe > rd_r.probe) ? rd_r.probe : car_r.probe) + PW'(1);
        if (32'(car_nxt.probe) >= 32'(max_probe)) over_nxt = 1'b1;
        idx_nxt = idx_r + AW'(1);
      end
    end
    if (cmd.rd) begin
      // restart walk from home for placement
      idx_nxt = car_r.hash[AW-1:0];
      car_nxt.probe = '0;
      walk_nxt = '0;
      probes_nxt = '0;
    end
    if (cmd.rm_clear) begin
      idx_nxt = idx_r + AW'(1);
      if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.shift_wr) idx_nxt = idx_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      clr_done_r <= 1'b0;
      cnt_r <= '0;
      out_valid <= 1'b0;
      idx_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + AW'(1);
        if (clr_r == AW'(CAPACITY - 1)) clr_done_r <= 1'b1;
      end
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      out_valid <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) op_r <= in_operation;
    dist_r <= dist_nxt;
    walk_r <= walk_nxt;
    car_r <= car_nxt;
    probes_r <= probes_nxt;
    over_r <= over_nxt;
    if (cmd.finish) begin
      out_status <= res_status;
      out_read_value <= (res_status == rhht_pkg::ST_FOUND) ? rd_r.value : 64'd0;
      out_read_bytes <= (res_status == rhht_pkg::ST_FOUND) ? rd_r.bytes : 4'd0;
      out_probe_count <= probes_r;
      out_over_probe <= over_r;
      out_entry_total <= 11'(cnt_r);
    end
  end

  assign sts.clr_done   = clr_done_r;
  assign sts.slot_valid = rd_r.valid;
  assign sts.slot_match = rd_r.valid && rd_r.hash == car_r.hash && rd_r.key == car_r.key;
  assign sts.stop_early = dist_r > rd_r.probe;
  assign sts.swap       = car_r.probe > rd_r.probe;
  assign sts.full       = ({1'b0, cnt_r} + (CW+1)'(1)) > limit;
  assign sts.shift_stop = !rd_r.valid || rd_r.probe == '0;
  assign sts.walk_end   = walk_r == PW'(CAPACITY - 1);
  assign sts.is_mut     = op_r == rhht_pkg::OP_INSERT || op_r == rhht_pkg::OP_UPDATE;
  assign sts.is_upd     = op_r == rhht_pkg::OP_UPDATE;
  assign sts.is_get     = op_r == rhht_pkg::OP_GET;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= CAPACITY) else $error("entry count above capacity");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.clr_step, cmd.upd_wr, cmd.rm_clear, cmd.shift_wr, cmd.gap_clr}) <= 1)
    else $error("two write commands at once");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.place_wr && !rd_r.valid |=> cnt_r == $past(cnt_r) + CW'(1))
    else $error("entry count missed an insert");
`endif
endmodule

>>> hdl/rhht_ctrl.sv
// rhht_ctrl: sequencer for clear, search, placement and backward shift
// depends on rhht_pkg
module rhht_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rhht_pkg::dp_sts_t  sts,
  output rhht_pkg::dp_cmd_t  cmd,
  output rhht_pkg::status_t  res_status
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SRD   = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_PRD   = 9'b000010000,
    S_PLACE = 9'b000100000,
    S_SHRD  = 9'b001000000,
    S_SHIFT = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  rhht_pkg::status_t stat_r, stat_nxt;

  assign busy = state_r != S_IDLE;
  assign res_status = stat_r;

  always_comb begin
    state_nxt = state_r;
    stat_nxt = stat_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = !sts.clr_done;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_SRD;
        end
      end
      // wait for the registered memory read
      S_SRD: state_nxt = S_SRCH;
      S_SRCH: begin
        if (sts.slot_match) begin
          cmd.srch_step = 1'b0;
          if (sts.is_mut) begin
            if (sts.is_upd) begin
              cmd.upd_wr = 1'b1;
              stat_nxt = rhht_pkg::ST_UPDATED;
            end else stat_nxt = rhht_pkg::ST_DUPLICATE;
            state_nxt = S_DONE;
          end else if (sts.is_get) begin
            stat_nxt = rhht_pkg::ST_FOUND;
            state_nxt = S_DONE;
          end else begin
            cmd.rm_clear = 1'b1;
            stat_nxt = rhht_pkg::ST_REMOVED;
            state_nxt = S_SHRD;
          end
        end else if (!sts.slot_valid || sts.stop_early || sts.walk_end) begin
          if (sts.is_mut && !sts.full) begin
            cmd.rd = 1'b1;
            stat_nxt = rhht_pkg::ST_INSERTED;
            state_nxt = S_PRD;
          end else begin
            stat_nxt = sts.is_mut ? rhht_pkg::ST_FULL : rhht_pkg::ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end else begin
          cmd.srch_step = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_PRD: state_nxt = S_PLACE;
      S_PLACE: begin
        cmd.place_wr = 1'b1;
        state_nxt = sts.slot_valid ? S_PRD : S_DONE;
      end
      S_SHRD: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (sts.shift_stop) begin
          // the slot vacated by the last move becomes empty
          cmd.gap_clr = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.shift_wr = 1'b1;
          state_nxt = S_SHRD;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      stat_r <= rhht_pkg::ST_NOT_FOUND;
    end else begin
      state_r <= state_nxt;
      stat_r <= stat_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> state_r == S_IDLE) else $error("finish not followed by idle");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("request taken while busy");
`endif
endmodule

>>> hdl/robin_hood_hash_table.sv
// robin_hood_hash_table: top level, config registers, controller and datapath
// depends on rhht_pkg, rhht_ctrl, rhht_datapath
//
// channel  direction  handshake           payload
// in_      request    start & !busy       operation hash key value value_bytes
// out_     result     out_valid (1 cyc)   status read_value read_bytes probe_count
//                                         over_probe entry_total
// cfg_     write      cfg_we              cfg_index cfg_data
//
// from one accepted request to the earliest next: S_SRD and S_SRCH per slot searched
// (one memory read port, registered data), S_PRD and S_PLACE per slot placed, S_SHRD and
// S_SHIFT per slot checked by the shift, plus S_IDLE and S_DONE; result shows as busy drops
// after reset a clearing pass writes every slot empty before busy drops
// results cannot be stalled; each shows for one cycle
module robin_hood_hash_table #(
  parameter int CAPACITY  = rhht_pkg::CAPACITY_DEF,
  parameter int KEY_BITS  = rhht_pkg::KEY_BITS_DEF,
  parameter int HASH_BITS = rhht_pkg::HASH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_hash,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  input  logic [3:0]  in_value_bytes,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [63:0] out_read_value,
  output logic [3:0]  out_read_bytes,
  output logic [10:0] out_probe_count,
  output logic        out_over_probe,
  output logic [10:0] out_entry_total,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  logic [15:0] max_probe_r;
  logic [10:0] load_limit_r;
  rhht_pkg::dp_cmd_t cmd;
  rhht_pkg::dp_sts_t sts;
  rhht_pkg::status_t res_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_probe_r <= rhht_pkg::MAX_PROBE_RST;
      load_limit_r <= rhht_pkg::LOAD_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rhht_pkg::REG_MAX_PROBE:  max_probe_r <= cfg_data;
        rhht_pkg::REG_LOAD_LIMIT: load_limit_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  rhht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .sts(sts), .cmd(cmd), .res_status(res_status)
  );

  rhht_datapath #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .HASH_BITS(HASH_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_operation), .in_hash(in_hash), .in_key(in_key),
    .in_value(in_value), .in_value_bytes(in_value_bytes),
    .max_probe(max_probe_r), .load_limit(load_limit_r), .res_status(res_status),
    .out_valid(out_valid), .out_status(out_status), .out_read_value(out_read_value),
    .out_read_bytes(out_read_bytes), .out_probe_count(out_probe_count),
    .out_over_probe(out_over_probe), .out_entry_total(out_entry_total)
  );
endmodule
